### rtl/sbda_pkg.sv
// shared types and constants for the signed binary to decimal ascii unit
// no dependencies

package sbda_pkg;

    localparam int VALUE_W        = 16;
    localparam int CHAR_W         = 8;
    localparam int BCD_W          = 4;
    localparam int DIGIT_CAP      = 20;
    localparam int MAX_DIGITS_DEF = 5;

    localparam logic [CHAR_W-1:0] ASCII_MINUS    = 8'h2D;
    localparam logic [CHAR_W-1:0] ASCII_ZERO     = 8'h30;
    localparam logic [BCD_W-1:0]  BCD_ADJ_LIMIT  = 4'd5;
    localparam logic [BCD_W-1:0]  BCD_ADJ_OFFSET = 4'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SHIFT,
        ST_LOCATE,
        ST_EMIT
    } state_t;

endpackage

### rtl/sbda_cell.sv
// one bcd digit cell of the shift-and-add-3 chain
// depends on sbda_pkg

module sbda_cell (
    input  logic                         aclk,
    input  logic                         clear,
    input  logic                         shift_en,
    input  logic                         bit_in,
    output logic                         bit_out,
    output logic [sbda_pkg::BCD_W-1:0]   digit
);

    logic [sbda_pkg::BCD_W-1:0] digit_reg;
    logic [sbda_pkg::BCD_W-1:0] digit_next;
    logic [sbda_pkg::BCD_W-1:0] adj;

    always_comb begin
        if (digit_reg >= sbda_pkg::BCD_ADJ_LIMIT) begin
            adj = digit_reg + sbda_pkg::BCD_ADJ_OFFSET;
        end else begin
            adj = digit_reg;
        end
        digit_next = {adj[sbda_pkg::BCD_W-2:0], bit_in};
    end

    always_ff @(posedge aclk) begin
        if (clear) begin
            digit_reg <= '0;
        end else if (shift_en) begin
            digit_reg <= digit_next;
        end
    end

    assign bit_out = adj[sbda_pkg::BCD_W-1];
    assign digit   = digit_reg;

endmodule

### rtl/signed_binary_to_decimal_ascii_unit.sv
// top level: signed 16-bit value in, decimal ascii characters out
// depends on sbda_pkg and sbda_cell
//
// usage
//   s_tdata carries one signed value per transfer; s_tready is high only
//   while the unit is idle, so one value is converted at a time.
//   m_tdata carries one ascii character per transfer: a minus sign for a
//   negative value, then the digits most significant first, no leading
//   zeros if the value fits MAX_DIGITS; m_tlast marks the final character of a value.
//   conversion runs the magnitude one bit per cycle through a row of bcd
//   digit cells (shift and add 3), then a locate step finds the leading
//   digit, then one character per cycle while m_tready is high.
//   the unit takes a new value while its last character still waits in
//   the output register.
//   when the receiver stalls, the output register holds its character and
//   the unit waits; nothing is dropped.
//   reset (aresetn low, synchronous) returns to idle and empties the
//   output register.

module signed_binary_to_decimal_ascii_unit #(
    parameter int MAX_DIGITS = sbda_pkg::MAX_DIGITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [sbda_pkg::VALUE_W-1:0]   s_tdata,   // [15:0] value
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [sbda_pkg::CHAR_W-1:0]    m_tdata,   // [7:0] character
    output logic                           m_tlast
);

    localparam int NumDigits = (MAX_DIGITS < 1) ? 1 :
                               (MAX_DIGITS > sbda_pkg::DIGIT_CAP) ? sbda_pkg::DIGIT_CAP :
                               MAX_DIGITS;
    localparam int IdxW = (NumDigits > 1) ? $clog2(NumDigits) : 1;
    localparam int CntW = $clog2(sbda_pkg::VALUE_W);
    localparam logic [CntW-1:0] CntLast = CntW'(sbda_pkg::VALUE_W - 1);
    localparam logic [IdxW-1:0] IdxTop  = IdxW'(NumDigits - 1);

    sbda_pkg::state_t state_reg, state_next;

    logic [sbda_pkg::VALUE_W-1:0] mag_reg, mag_next;
    logic [CntW-1:0]              cnt_reg, cnt_next;
    logic                         neg_reg, neg_next;
    logic                         ovf_reg, ovf_next;
    logic [IdxW-1:0]              idx_reg, idx_next;
    logic                         m_valid_reg, m_valid_next;
    logic [sbda_pkg::CHAR_W-1:0]  m_data_reg, m_data_next;
    logic                         m_last_reg, m_last_next;

    logic                         in_xfer;
    logic                         shift_en;
    logic                         out_free;
    logic [IdxW-1:0]              lead_idx;
    logic [NumDigits:0]           carry;
    logic [sbda_pkg::BCD_W-1:0]   digits [NumDigits];

    assign s_tready = (state_reg == sbda_pkg::ST_IDLE);
    assign in_xfer  = s_tvalid && s_tready;
    assign shift_en = (state_reg == sbda_pkg::ST_SHIFT);
    assign out_free = !m_valid_reg || m_tready;

    assign carry[0] = mag_reg[sbda_pkg::VALUE_W-1];

    for (genvar g = 0; g < NumDigits; g++) begin : g_cell
        sbda_cell u_cell (
            .aclk     (aclk),
            .clear    (in_xfer),
            .shift_en (shift_en),
            .bit_in   (carry[g]),
            .bit_out  (carry[g+1]),
            .digit    (digits[g])
        );
    end

    // highest nonzero digit, zero value gives digit 0
    always_comb begin
        lead_idx = '0;
        for (int i = 0; i < NumDigits; i++) begin
            if (digits[i] != '0) begin
                lead_idx = IdxW'(i);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= sbda_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
        mag_reg    <= mag_next;
        cnt_reg    <= cnt_next;
        neg_reg    <= neg_next;
        ovf_reg    <= ovf_next;
        idx_reg    <= idx_next;
        m_data_reg <= m_data_next;
        m_last_reg <= m_last_next;
    end

    always_comb begin
        state_next   = state_reg;
        mag_next     = mag_reg;
        cnt_next     = cnt_reg;
        neg_next     = neg_reg;
        ovf_next     = ovf_reg;
        idx_next     = idx_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;
        m_last_next  = m_last_reg;

        case (state_reg)
            sbda_pkg::ST_IDLE: begin
                if (in_xfer) begin
                    neg_next   = s_tdata[sbda_pkg::VALUE_W-1];
                    mag_next   = s_tdata[sbda_pkg::VALUE_W-1] ? (~s_tdata + 1'b1) : s_tdata;
                    cnt_next   = '0;
                    ovf_next   = 1'b0;
                    state_next = sbda_pkg::ST_SHIFT;
                end
            end
            sbda_pkg::ST_SHIFT: begin
                mag_next = {mag_reg[sbda_pkg::VALUE_W-2:0], 1'b0};
                cnt_next = cnt_reg + 1'b1;
                ovf_next = ovf_reg | carry[NumDigits];
                if (cnt_reg == CntLast) begin
                    state_next = sbda_pkg::ST_LOCATE;
                end
            end
            sbda_pkg::ST_LOCATE: begin
                // digits dropped above the top cell force all cells out
                idx_next   = ovf_reg ? IdxTop : lead_idx;
                state_next = sbda_pkg::ST_EMIT;
            end
            sbda_pkg::ST_EMIT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    if (neg_reg) begin
                        m_data_next = sbda_pkg::ASCII_MINUS;
                        m_last_next = 1'b0;
                        neg_next    = 1'b0;
                    end else begin
                        m_data_next = sbda_pkg::ASCII_ZERO |
                                      sbda_pkg::CHAR_W'(digits[idx_reg]);
                        m_last_next = (idx_reg == '0);
                        idx_next    = idx_reg - 1'b1;
                        if (idx_reg == '0) begin
                            state_next = sbda_pkg::ST_IDLE;
                        end
                    end
                end
            end
            default: begin
                state_next = sbda_pkg::ST_IDLE;
            end
        endcase
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

endmodule
